// ===== hw/rtl/motion_sensor_peak_smoother_top_assert.svh =====
// assertion macros shared by the motion sensor peak smoother rtl
// no dependencies; include by bare file name
`ifndef MOTION_SENSOR_PEAK_SMOOTHER_TOP_ASSERT_SVH
`define MOTION_SENSOR_PEAK_SMOOTHER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MSPS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msps assertion failed");

// next-cycle implication, disabled while in reset
`define MSPS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msps assertion failed");

`endif

// ===== hw/rtl/msps_pkg.sv =====
// shared types and constants of the motion sensor peak smoother
// no dependencies
package msps_pkg;

    // default sizes
    localparam int WINDOW_DEF   = 20;
    localparam int CHANNELS_DEF = 2;

    // field widths
    localparam int CHANNEL_W = 2;
    localparam int RAW_W     = 12;
    localparam int LEVEL_W   = 7;
    localparam int WEIGHT_W  = 9;
    localparam int ACC_W     = 16;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // arithmetic constants
    localparam logic [RAW_W-1:0]    MID_CODE   = 12'd2048;
    localparam logic [LEVEL_W-1:0]  FULL_SCALE = 7'd100;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

    // register reset values
    localparam logic [LEVEL_W-1:0]  DEAD_ZONE_RST = 7'd10;
    localparam logic [LEVEL_W-1:0]  CEILING_RST   = 7'd100;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 9'd128;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_DEAD_ZONE = 2'd0;
    localparam logic [1:0] REG_CEILING   = 2'd1;
    localparam logic [1:0] REG_WEIGHT    = 2'd2;

    typedef struct packed {
        logic [LEVEL_W-1:0]  dead_zone;
        logic [LEVEL_W-1:0]  ceiling;
        logic [WEIGHT_W-1:0] smoothing_weight;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_SCAN,
        S_LAST,
        S_MUL1,
        S_MUL2,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic do_write;
        logic scan_rd;
        logic mul1;
        logic mul2;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ch_ok;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== hw/rtl/msps_in_if.sv =====
// input item channel: sensor channel number and raw converter sample
// depends on msps_pkg
interface msps_in_if;
    import msps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] channel;
    logic [RAW_W-1:0]     raw_sample;

    modport source (output valid, output channel, output raw_sample, input ready);
    modport sink   (input valid, input channel, input raw_sample, output ready);
endinterface

// ===== hw/rtl/msps_out_if.sv =====
// result item channel: smoothed motion level
// depends on msps_pkg
interface msps_out_if;
    import msps_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

// ===== hw/rtl/msps_cfg.sv =====
// apb-style configuration registers: dead zone, ceiling, smoothing weight
// depends on msps_pkg
module msps_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msps_pkg::PADDR_W-1:0]  paddr,
    input  logic [msps_pkg::PDATA_W-1:0]  pwdata,
    output logic [msps_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output msps_pkg::cfg_t                cfg
);
    import msps_pkg::*;

    logic [LEVEL_W-1:0]  dead_zone_reg;
    logic [LEVEL_W-1:0]  ceiling_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                wr_en;
    logic [1:0]          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= DEAD_ZONE_RST;
            ceiling_reg   <= CEILING_RST;
            weight_reg    <= WEIGHT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DEAD_ZONE: dead_zone_reg <= pwdata[LEVEL_W-1:0];
                REG_CEILING:   ceiling_reg   <= pwdata[LEVEL_W-1:0];
                REG_WEIGHT:    weight_reg    <= pwdata[WEIGHT_W-1:0];
                default:       ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            REG_DEAD_ZONE: prdata = PDATA_W'(dead_zone_reg);
            REG_CEILING:   prdata = PDATA_W'(ceiling_reg);
            REG_WEIGHT:    prdata = PDATA_W'(weight_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.dead_zone        = dead_zone_reg;
    assign cfg.ceiling          = ceiling_reg;
    assign cfg.smoothing_weight = weight_reg;
endmodule

// ===== hw/rtl/msps_ctrl.sv =====
// controller state machine: sequences accept, window write, scan, average, output
// depends on msps_pkg
module msps_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  msps_pkg::ctrl_sts_t   sts,
    output msps_pkg::ctrl_cmd_t   cmd
);
    import msps_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.ch_ok ? S_WRITE : S_FINISH;
                end
            end
            S_WRITE:
            begin
                cmd.do_write = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== hw/rtl/msps_dp.sv =====
// datapath: magnitude, per-channel window memory, peak scan, limiter, average
// depends on msps_pkg and the assertion macro header
`include "motion_sensor_peak_smoother_top_assert.svh"

module msps_dp #(
    parameter int WINDOW   = msps_pkg::WINDOW_DEF,
    parameter int CHANNELS = msps_pkg::CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  msps_pkg::cfg_t                  cfg,
    input  logic [msps_pkg::CHANNEL_W-1:0]  channel,
    input  logic [msps_pkg::RAW_W-1:0]      raw_sample,
    input  msps_pkg::ctrl_cmd_t             cmd,
    output msps_pkg::ctrl_sts_t             sts,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [msps_pkg::LEVEL_W-1:0]    out_level
);
    import msps_pkg::*;

    localparam int DEPTH  = CHANNELS * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W = RAW_W + LEVEL_W - 1;

    // window memory, one circular buffer per channel
    logic [LEVEL_W-1:0] win_mem [DEPTH];
    logic [LEVEL_W-1:0] rd_data_reg;

    // per-channel write pointer, fill count and average
    logic [IDX_W-1:0]   wp_reg     [CHANNELS];
    logic [CNT_W-1:0]   fill_reg   [CHANNELS];
    logic [LEVEL_W-1:0] smooth_reg [CHANNELS];

    logic [CH_W-1:0]    ch_reg;
    logic [LEVEL_W-1:0] mag_reg;
    logic [IDX_W-1:0]   scan_cnt_reg;
    logic               rd_vld_reg;
    logic               rd_ok_reg;
    logic [LEVEL_W-1:0] peak_reg;
    logic [LEVEL_W-1:0] lim_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [LEVEL_W-1:0] lvl_reg;
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_level_reg;

    logic [31:0]         ch_wide;
    logic                ch_ok;
    logic [RAW_W-1:0]    dev;
    logic [PROD_W-1:0]   mag_prod;
    logic [IDX_W-1:0]    wp_cur;
    logic [CNT_W-1:0]    fill_cur;
    logic [LEVEL_W-1:0]  old_lvl;
    logic [ADDR_W-1:0]   base_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [LEVEL_W-1:0]  peak_dz;
    logic [LEVEL_W-1:0]  peak_lim;
    logic [WEIGHT_W-1:0] w_eff;
    logic [WEIGHT_W-1:0] w_inv;
    logic [ACC_W-1:0]    acc_next;
    logic [ACC_W-1:0]    sum_next;

    // input decode and magnitude: |raw - mid| * 100 / 2048
    assign ch_wide  = 32'(channel);
    assign ch_ok    = (ch_wide < 32'(CHANNELS));
    assign dev      = (raw_sample >= MID_CODE) ? (raw_sample - MID_CODE)
                                               : (MID_CODE - raw_sample);
    assign mag_prod = PROD_W'(dev) * PROD_W'(FULL_SCALE);

    // current channel state
    assign wp_cur    = wp_reg[ch_reg];
    assign fill_cur  = fill_reg[ch_reg];
    assign old_lvl   = smooth_reg[ch_reg];
    assign base_addr = ADDR_W'(ADDR_W'(ch_reg) * ADDR_W'(WINDOW));
    assign wr_addr   = ADDR_W'(base_addr + ADDR_W'(wp_cur));
    assign rd_addr   = ADDR_W'(base_addr + ADDR_W'(scan_cnt_reg));

    // dead zone first, then ceiling clamp
    assign peak_dz  = (peak_reg < cfg.dead_zone) ? '0 : peak_reg;
    assign peak_lim = (peak_dz > cfg.ceiling) ? cfg.ceiling : peak_dz;

    // average weight, saturated at one
    assign w_eff    = (cfg.smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE
                                                          : cfg.smoothing_weight;
    assign w_inv    = WEIGHT_ONE - w_eff;
    assign acc_next = ACC_W'(old_lvl) * ACC_W'(w_inv);
    assign sum_next = ACC_W'(acc_reg + ACC_W'(ACC_W'(lim_reg) * ACC_W'(w_eff)));

    // window memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.do_write)
        begin
            win_mem[wr_addr] <= mag_reg;
        end
        rd_data_reg <= win_mem[rd_addr];
    end

    // item payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mag_reg <= mag_prod[PROD_W-1 -: LEVEL_W];
        end
        if (cmd.mul1)
        begin
            acc_reg <= acc_next;
            lim_reg <= peak_lim;
        end
    end

    // channel, scan counter, peak and level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg       <= '0;
            scan_cnt_reg <= '0;
            rd_vld_reg   <= 1'b0;
            rd_ok_reg    <= 1'b0;
            peak_reg     <= '0;
            lvl_reg      <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_rd;
            if (cmd.accept)
            begin
                if (ch_ok)
                begin
                    ch_reg <= ch_wide[CH_W-1:0];
                end
                else
                begin
                    lvl_reg <= '0;
                end
            end
            if (cmd.do_write)
            begin
                scan_cnt_reg <= '0;
                peak_reg     <= '0;
            end
            if (cmd.scan_rd)
            begin
                rd_ok_reg    <= (CNT_W'(scan_cnt_reg) < fill_cur);
                scan_cnt_reg <= IDX_W'(scan_cnt_reg + 1'b1);
            end
            // compare one window entry a cycle; entries not yet written are skipped
            if (rd_vld_reg && rd_ok_reg && (rd_data_reg > peak_reg))
            begin
                peak_reg <= rd_data_reg;
            end
            if (cmd.mul2)
            begin
                lvl_reg <= sum_next[8 +: LEVEL_W];
            end
        end
    end

    // per-channel pointer, fill count and average state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                wp_reg[c]     <= '0;
                fill_reg[c]   <= '0;
                smooth_reg[c] <= '0;
            end
        end
        else
        begin
            if (cmd.do_write)
            begin
                wp_reg[ch_reg] <= (wp_cur == IDX_W'(WINDOW - 1)) ? '0
                                                                 : IDX_W'(wp_cur + 1'b1);
                if (fill_cur != CNT_W'(WINDOW))
                begin
                    fill_reg[ch_reg] <= CNT_W'(fill_cur + 1'b1);
                end
            end
            if (cmd.mul2)
            begin
                smooth_reg[ch_reg] <= sum_next[8 +: LEVEL_W];
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_level_reg <= '0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
            out_level_reg <= lvl_reg;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_level     = out_level_reg;
    assign sts.ch_ok     = ch_ok;
    assign sts.scan_last = (scan_cnt_reg == IDX_W'(WINDOW - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;

    // checks
    `MSPS_ASSERT_IMPL(a_level_range, clk, rst_n, out_valid_reg, out_level_reg <= FULL_SCALE)
    `MSPS_ASSERT_IMPL(a_fill_range, clk, rst_n, 1'b1, fill_cur <= CNT_W'(WINDOW))
    `MSPS_ASSERT_IMPL(a_wp_tracks_fill, clk, rst_n, fill_cur < CNT_W'(WINDOW),
                      CNT_W'(wp_cur) == fill_cur)
    `MSPS_ASSERT_NEXT(a_avg_stored, clk, rst_n, cmd.mul2, smooth_reg[ch_reg] == lvl_reg)
endmodule

// ===== hw/rtl/motion_sensor_peak_smoother_top.sv =====
// motion sensor peak smoother top: config regs, controller, datapath
// an item goes through states write, scan, last, mul1, mul2 and finish (finish alone for a
// channel out of range); the window scan does one read a cycle, and a new item is taken only
// in idle, while the previous result may still wait in the output register
// reset (rst_n, async low): windows and averages read as zero, registers to defaults
module motion_sensor_peak_smoother_top #(
    parameter int WINDOW   = msps_pkg::WINDOW_DEF,
    parameter int CHANNELS = msps_pkg::CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msps_pkg::PADDR_W-1:0]  paddr,
    input  logic [msps_pkg::PDATA_W-1:0]  pwdata,
    output logic [msps_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    msps_in_if.sink                       in_ch,
    msps_out_if.source                    out_ch
);
    import msps_pkg::*;

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // configuration registers
    msps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // controller
    msps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    msps_dp #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .channel    (in_ch.channel),
        .raw_sample (in_ch.raw_sample),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_level  (out_ch.level)
    );
endmodule

// ===== tb/tb_motion_sensor_peak_smoother_top.sv =====
// self-checking testbench for motion_sensor_peak_smoother_top
// depends on msps_pkg, msps_in_if, msps_out_if and the top level rtl
`timescale 1ns / 100ps

module tb_motion_sensor_peak_smoother_top;
    import msps_pkg::*;

    localparam int WIN       = WINDOW_DEF;
    localparam int NCH       = CHANNELS_DEF;
    localparam int LATENCY   = WIN + 5;
    localparam int LONG_HOLD = 400;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 122;
    localparam int DIR_ROWS  = 17;

    // one directed row: register setting, the item, and a typed level where obvious
    typedef struct packed {
        logic [LEVEL_W-1:0]   dz;
        logic [LEVEL_W-1:0]   ceil_lvl;
        logic [WEIGHT_W-1:0]  wt;
        logic [CHANNEL_W-1:0] ch;
        logic [RAW_W-1:0]     raw;
        logic                 known;
        logic [LEVEL_W-1:0]   lvl;
    } dir_row_t;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    msps_in_if  in_if();
    msps_out_if out_if();

    motion_sensor_peak_smoother_top #(
        .WINDOW   (WIN),
        .CHANNELS (NCH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_if),
        .out_ch  (out_if)
    );

    // shadow of the block: register copy, magnitude windows and running averages
    cfg_t               cur_cfg;
    logic [LEVEL_W-1:0] mag_hist [NCH][WIN];
    logic [LEVEL_W-1:0] avg_level [NCH];
    logic [LEVEL_W-1:0] level_due [$];

    int errors;
    int items_sent;
    int bad_ch_items;
    int levels_seen;
    int settings_used;
    int dz_hits;
    int clamp_hits;
    int burst_left;
    bit no_idle;
    int hold_asks;
    logic [LEVEL_W-1:0] want_level;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{7'd10,  7'd100, 9'd128, 2'd0, 12'd0,     1'b1, 7'd50},
        '{7'd10,  7'd100, 9'd128, 2'd1, 12'd4095,  1'b1, 7'd49},
        '{7'd10,  7'd100, 9'd128, 2'd2, 12'd0,     1'b1, 7'd0},
        '{7'd10,  7'd100, 9'd128, 2'd3, 12'd4095,  1'b1, 7'd0},
        '{7'd10,  7'd100, 9'd128, 2'd0, 12'd2048,  1'b0, 7'd0},
        '{7'd10,  7'd100, 9'd128, 2'd1, 12'd2047,  1'b0, 7'd0},
        '{7'd10,  7'd100, 9'd128, 2'd0, 12'd4095,  1'b0, 7'd0},
        '{7'd10,  7'd100, 9'd0,   2'd0, 12'd0,     1'b0, 7'd0},
        '{7'd0,   7'd127, 9'd300, 2'd1, 12'd0,     1'b1, 7'd100},
        '{7'd100, 7'd40,  9'd256, 2'd0, 12'd1000,  1'b1, 7'd40},
        '{7'd127, 7'd0,   9'd511, 2'd1, 12'd4095,  1'b1, 7'd0},
        '{7'd127, 7'd0,   9'd511, 2'd0, 12'd2047,  1'b1, 7'd0},
        '{7'd0,   7'd0,   9'd256, 2'd0, 12'd0,     1'b1, 7'd0},
        '{7'd0,   7'd100, 9'd1,   2'd0, 12'd2049,  1'b0, 7'd0},
        '{7'd5,   7'd90,  9'd200, 2'd1, 12'h555,   1'b0, 7'd0},
        '{7'd5,   7'd90,  9'd200, 2'd1, 12'haaa,   1'b0, 7'd0},
        '{7'd5,   7'd90,  9'd200, 2'd2, 12'h555,   1'b1, 7'd0}
    };

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // run limit
    initial
    begin
        #2000000;
        $display("tb_motion_sensor_peak_smoother_top NOT OK");
        $finish;
    end

    // new smoothed level for one item, updating the shadow state
    function automatic logic [LEVEL_W-1:0] next_level(input logic [CHANNEL_W-1:0] ch,
                                                       input logic [RAW_W-1:0] raw);
        int dev;
        int mag;
        int peak;
        int w;
        int lvl;
        if (ch >= NCH)
        begin
            bad_ch_items++;
            return '0;
        end
        dev = (raw >= int'(MID_CODE)) ? raw - int'(MID_CODE) : int'(MID_CODE) - raw;
        mag = dev * int'(FULL_SCALE) / int'(MID_CODE);
        for (int i = 0; i < WIN - 1; i++)
            mag_hist[ch][i] = mag_hist[ch][i+1];
        mag_hist[ch][WIN-1] = LEVEL_W'(mag);
        // peak over the whole window, newest entry included
        peak = 0;
        for (int i = 0; i < WIN; i++)
            if (mag_hist[ch][i] > peak)
                peak = mag_hist[ch][i];
        // dead zone first, then the ceiling clamp
        if (peak < cur_cfg.dead_zone)
        begin
            peak = 0;
            dz_hits++;
        end
        if (peak > cur_cfg.ceiling)
        begin
            peak = cur_cfg.ceiling;
            clamp_hits++;
        end
        // weights above one act as one
        w = (cur_cfg.smoothing_weight > WEIGHT_ONE) ? int'(WEIGHT_ONE)
                                                    : int'(cur_cfg.smoothing_weight);
        lvl = (avg_level[ch] * (int'(WEIGHT_ONE) - w) + peak * w) >> 8;
        avg_level[ch] = LEVEL_W'(lvl);
        return LEVEL_W'(lvl);
    endfunction

    // random channel and reading, mostly near rest so the dead zone gets exercised
    function automatic logic [CHANNEL_W+RAW_W-1:0] random_reading();
        logic [CHANNEL_W-1:0] ch;
        int raw;
        ch = ($urandom_range(0, 7) == 0) ? CHANNEL_W'($urandom_range(2, 3))
                                         : CHANNEL_W'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: raw = 1648 + $urandom_range(0, 800);
            5, 6, 7:       raw = $urandom_range(0, 4095);
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       raw = 0;
                    1:       raw = 4095;
                    2:       raw = 2047;
                    default: raw = 2049;
                endcase
            end
            default:       raw = 2048;
        endcase
        return {ch, RAW_W'(raw)};
    endfunction

    // wait until every expected level has come back
    task automatic wait_drained();
        while (level_due.size() != 0)
            @(posedge clk);
    endtask

    // apb write: setup cycle then access cycle
    task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // apb read back of one register against its shadow value
    task automatic reg_check(input logic [1:0] idx, input logic [PDATA_W-1:0] want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $display("%0t: register %0d read expected %0d got %0d", $time, idx, want, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // new register setting once the block is idle; upper data bits carry noise
    task automatic apply_cfg(input logic [LEVEL_W-1:0] dz, input logic [LEVEL_W-1:0] cl,
                             input logic [WEIGHT_W-1:0] wt);
        wait_drained();
        reg_write(REG_DEAD_ZONE, PDATA_W'({$urandom() >> LEVEL_W, dz}));
        reg_write(REG_CEILING,   PDATA_W'({$urandom() >> LEVEL_W, cl}));
        reg_write(REG_WEIGHT,    PDATA_W'({$urandom() >> WEIGHT_W, wt}));
        cur_cfg.dead_zone        = dz;
        cur_cfg.ceiling          = cl;
        cur_cfg.smoothing_weight = wt;
        settings_used++;
        reg_check(REG_DEAD_ZONE, PDATA_W'(dz));
        reg_check(REG_CEILING,   PDATA_W'(cl));
        reg_check(REG_WEIGHT,    PDATA_W'(wt));
    endtask

    // offer one item, with bursts and gaps unless told otherwise
    task automatic send_item(input logic [CHANNEL_W-1:0] ch, input logic [RAW_W-1:0] raw,
                             input logic known, input logic [LEVEL_W-1:0] lvl,
                             input bit allow_gap);
        int gap;
        logic [LEVEL_W-1:0] pred;
        if (allow_gap && !no_idle)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                if (gap > 0)
                begin
                    in_if.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        in_if.valid      <= 1'b1;
        in_if.channel    <= ch;
        in_if.raw_sample <= raw;
        do @(posedge clk); while (!in_if.ready);
        items_sent++;
        pred = next_level(ch, raw);
        level_due.push_back(known ? lvl : pred);
    endtask

    // receiver: stall pattern of its own, plus long hold-offs on request
    rx_mode_t rx_mode;
    int       rx_left;
    int       hold_left;
    int       holds_started;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_if.ready  <= 1'b0;
            rx_mode       = RX_STREAM;
            rx_left       = 0;
            hold_left     = 0;
            holds_started = 0;
        end
        else
        begin
            if (holds_started != hold_asks)
            begin
                holds_started = hold_asks;
                hold_left     = LONG_HOLD;
            end
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(50, 300);
            end
            rx_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_STREAM: out_if.ready <= 1'b1;
                    RX_MOSTLY: out_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   out_if.ready <= ((rx_left % 8) >= 3);
                endcase
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (level_due.size() == 0)
            begin
                $display("%0t: level %0d arrived with nothing expected", $time, out_if.level);
                errors++;
            end
            else
            begin
                want_level = level_due.pop_front();
                levels_seen++;
                if (out_if.level !== want_level)
                begin
                    $display("%0t: level expected %0d got %0d", $time, want_level,
                             out_if.level);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        dir_row_t row;
        logic [CHANNEL_W+RAW_W-1:0] rd;

        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_if.valid      = 1'b0;
        in_if.channel    = '0;
        in_if.raw_sample = '0;
        errors           = 0;
        items_sent       = 0;
        bad_ch_items     = 0;
        levels_seen      = 0;
        settings_used    = 0;
        dz_hits          = 0;
        clamp_hits       = 0;
        burst_left       = 0;
        no_idle          = 1'b0;
        hold_asks        = 0;
        cur_cfg.dead_zone        = DEAD_ZONE_RST;
        cur_cfg.ceiling          = CEILING_RST;
        cur_cfg.smoothing_weight = WEIGHT_RST;
        for (int c = 0; c < NCH; c++)
        begin
            avg_level[c] = '0;
            for (int i = 0; i < WIN; i++)
                mag_hist[c][i] = '0;
        end

        // reset
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, register setting changed between rows where it differs
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = dir_table[r];
            if (row.dz != cur_cfg.dead_zone || row.ceil_lvl != cur_cfg.ceiling ||
                row.wt != cur_cfg.smoothing_weight)
            begin
                in_if.valid <= 1'b0;
                apply_cfg(row.dz, row.ceil_lvl, row.wt);
            end
            send_item(row.ch, row.raw, row.known, row.lvl, 1'b1);
        end
        in_if.valid <= 1'b0;

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: apply_cfg('0, '0, '0);
                1: apply_cfg('1, '1, '1);
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: apply_cfg(LEVEL_W'($urandom_range(0, 100)),
                                     LEVEL_W'($urandom_range(0, 100)),
                                     WEIGHT_W'($urandom_range(0, 256)));
                        1: apply_cfg(LEVEL_W'($urandom()), LEVEL_W'($urandom()),
                                     WEIGHT_W'($urandom()));
                        2: apply_cfg(LEVEL_W'($urandom_range(0, 20)),
                                     LEVEL_W'($urandom_range(60, 127)),
                                     WEIGHT_W'($urandom_range(16, 256)));
                        default: apply_cfg(LEVEL_W'($urandom_range(50, 127)),
                                           LEVEL_W'($urandom_range(0, 49)),
                                           WEIGHT_W'($urandom()));
                    endcase
                end
            endcase
            no_idle = (ph % 3 == 2);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                // long receiver hold with the sender pushing, then a full pause
                if ((ph == 2 || ph == 6) && n == 60)
                begin
                    hold_asks++;
                    for (int k = 0; k < 30; k++)
                    begin
                        rd = random_reading();
                        send_item(rd[CHANNEL_W+RAW_W-1:RAW_W], rd[RAW_W-1:0], 1'b0, '0, 1'b0);
                    end
                    in_if.valid <= 1'b0;
                    wait_drained();
                end
                rd = random_reading();
                send_item(rd[CHANNEL_W+RAW_W-1:RAW_W], rd[RAW_W-1:0], 1'b0, '0, 1'b1);
            end
            in_if.valid <= 1'b0;
        end

        // drain and watch for stray results
        wait_drained();
        repeat (2 * LATENCY) @(posedge clk);

        $display("run covered %0d items (%0d on out-of-range channels), %0d levels checked",
                 items_sent, bad_ch_items, levels_seen);
        $display("%0d register settings, %0d dead-zone zeroings, %0d ceiling clamps",
                 settings_used, dz_hits, clamp_hits);
        if (errors == 0)
            $display("tb_motion_sensor_peak_smoother_top OK");
        else
            $display("tb_motion_sensor_peak_smoother_top NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/msps_pkg.sv
hw/rtl/msps_in_if.sv
hw/rtl/msps_out_if.sv
hw/rtl/msps_cfg.sv
hw/rtl/msps_ctrl.sv
hw/rtl/msps_dp.sv
hw/rtl/motion_sensor_peak_smoother_top.sv
tb/tb_motion_sensor_peak_smoother_top.sv
